>>> rtl/pyr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pyr_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned CntW    = $clog2(MAX_DIM);
  localparam int unsigned DimW    = CntW + 1;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DimW-1:0] MaxDimV = DimW'(MAX_DIM);
  localparam logic [DimW-1:0] MinWidth = DimW'(2);
  localparam logic [DimW-1:0] MinHeight = DimW'(1);

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BYTE_ORDER   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  // Byte order of the packed stream
  typedef enum logic {
    ORDER_YUYV = 1'b0,
    ORDER_UYVY = 1'b1
  } order_e;

  typedef struct packed {
    order_e          byte_order;
    logic [DimW-1:0] frame_width;
    logic [DimW-1:0] frame_height;
  } cfg_t;

  // One complete macropixel with its end flags
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] blue_chroma;
    logic [7:0] red_chroma;
    logic       end_of_line;
    logic       end_of_frame;
  } mpix_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

endpackage

`default_nettype wire

>>> rtl/pyr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pyr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface pyr_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       second_of_pair;
  logic       end_of_line;
  logic       end_of_frame;

  modport source (output valid, output blue, output green, output red,
                  output second_of_pair, output end_of_line, output end_of_frame,
                  input ready);
  modport sink (input valid, input blue, input green, input red,
                input second_of_pair, input end_of_line, input end_of_frame,
                output ready);
endinterface

interface pyr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pyr_unpack.sv
`timescale 1ns / 1ps
`default_nettype none

module pyr_unpack (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  pyr_byte_if.sink          stream_i,
  input  wire pyr_pkg::cfg_t cfg_i,
  input  wire logic         slot_free_i,
  output logic              mp_load_o,
  output pyr_pkg::mpix_t    mp_o
);
  import pyr_pkg::*;

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      y0_q, y0_d, y1_q, y1_d, u_q, u_d, v_q, v_d;
  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic            accept;
  logic            last_byte;
  logic [DimW-1:0] w_even, w_eff, h_eff;
  logic [DimW-1:0] col_next, row_next;
  logic            eol, eof;

  assign last_byte      = (phase_q == 2'd3);
  assign stream_i.ready = !last_byte || slot_free_i;
  assign accept         = stream_i.valid && stream_i.ready;

  // Round the width down to even and clamp the frame size to the usable range
  always_comb begin
    w_even = {cfg_i.frame_width[DimW-1:1], 1'b0};
    if (w_even < MinWidth) begin
      w_eff = MinWidth;
    end else if (w_even > MaxDimV) begin
      w_eff = MaxDimV;
    end else begin
      w_eff = w_even;
    end
    if (cfg_i.frame_height < MinHeight) begin
      h_eff = MinHeight;
    end else if (cfg_i.frame_height > MaxDimV) begin
      h_eff = MaxDimV;
    end else begin
      h_eff = cfg_i.frame_height;
    end
  end

  assign col_next = {1'b0, col_q} + DimW'(2);
  assign row_next = {1'b0, row_q} + DimW'(1);
  assign eol      = (col_next >= w_eff);
  assign eof      = eol && (row_next >= h_eff);

  // Steer the byte to its slot under the order now in force
  always_comb begin
    y0_d = y0_q;
    y1_d = y1_q;
    u_d  = u_q;
    v_d  = v_q;
    if (cfg_i.byte_order == ORDER_YUYV) begin
      case (phase_q)
        2'd0:    y0_d = stream_i.stream_byte;
        2'd1:    u_d  = stream_i.stream_byte;
        2'd2:    y1_d = stream_i.stream_byte;
        2'd3:    v_d  = stream_i.stream_byte;
        default: y0_d = y0_q;
      endcase
    end else begin
      case (phase_q)
        2'd0:    u_d  = stream_i.stream_byte;
        2'd1:    y0_d = stream_i.stream_byte;
        2'd2:    v_d  = stream_i.stream_byte;
        2'd3:    y1_d = stream_i.stream_byte;
        default: u_d  = u_q;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q + 2'd1;
    col_d   = col_q;
    row_d   = row_q;
    if (last_byte) begin
      if (eol) begin
        col_d = '0;
        row_d = eof ? '0 : row_next[CntW-1:0];
      end else begin
        col_d = col_next[CntW-1:0];
      end
    end
  end

  assign mp_load_o = accept && last_byte;
  assign mp_o      = '{luma_first: y0_d, luma_second: y1_d, blue_chroma: u_d,
                       red_chroma: v_d, end_of_line: eol, end_of_frame: eof};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      y0_q    <= '0;
      y1_q    <= '0;
      u_q     <= '0;
      v_q     <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      y0_q    <= y0_d;
      y1_q    <= y1_d;
      u_q     <= u_d;
      v_q     <= v_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pyr_convert.sv
`timescale 1ns / 1ps
`default_nettype none

module pyr_convert (
  input  wire logic [7:0] luma_i,
  input  wire logic [7:0] blue_chroma_i,
  input  wire logic [7:0] red_chroma_i,
  output pyr_pkg::rgb_t   rgb_o
);
  import pyr_pkg::*;

  logic signed [7:0]  u, v;
  logic signed [19:0] prod_b, prod_r, sum_g;
  logic signed [9:0]  cb, cr, cg;
  logic signed [10:0] luma_s, b_raw, g_raw, r_raw;

  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  // Offset binary to two's complement: subtract 128
  assign u = $signed({~blue_chroma_i[7], blue_chroma_i[6:0]});
  assign v = $signed({~red_chroma_i[7], red_chroma_i[6:0]});

  assign prod_b = 20'(u) * $signed(20'd454);
  assign prod_r = 20'(v) * $signed(20'd359);
  assign sum_g  = 20'(u) * $signed(20'd88) + 20'(v) * $signed(20'd183);

  // Arithmetic shift by 8, floor rounding
  assign cb = prod_b[17:8];
  assign cr = prod_r[17:8];
  assign cg = sum_g[17:8];

  assign luma_s = $signed({3'b000, luma_i});
  assign b_raw  = luma_s + 11'(cb);
  assign g_raw  = luma_s - 11'(cg);
  assign r_raw  = luma_s + 11'(cr);

  assign rgb_o = '{blue: clamp8(b_raw), green: clamp8(g_raw), red: clamp8(r_raw)};

endmodule

`default_nettype wire

>>> rtl/pyr_pair_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module pyr_pair_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           mp_load_i,
  input  wire pyr_pkg::mpix_t mp_i,
  output logic                slot_free_o,
  pyr_pix_if.source           pixel_o
);
  import pyr_pkg::*;

  mpix_t mp_q;
  logic  valid_q, valid_d;
  logic  sel_q, sel_d;
  logic  xfer;
  rgb_t  rgb;

  assign xfer        = pixel_o.valid && pixel_o.ready;
  assign slot_free_o = !valid_q || (xfer && sel_q);

  pyr_convert u_convert (
    .luma_i        (sel_q ? mp_q.luma_second : mp_q.luma_first),
    .blue_chroma_i (mp_q.blue_chroma),
    .red_chroma_i  (mp_q.red_chroma),
    .rgb_o         (rgb)
  );

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (xfer) begin
      sel_d = !sel_q;
      if (sel_q) begin
        valid_d = 1'b0;
      end
    end
    if (mp_load_i) begin
      valid_d = 1'b1;
      sel_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mp_load_i) begin
      mp_q <= mp_i;
    end
  end

  assign pixel_o.valid          = valid_q;
  assign pixel_o.blue           = rgb.blue;
  assign pixel_o.green          = rgb.green;
  assign pixel_o.red            = rgb.red;
  assign pixel_o.second_of_pair = sel_q;
  assign pixel_o.end_of_line    = sel_q && mp_q.end_of_line;
  assign pixel_o.end_of_frame   = sel_q && mp_q.end_of_frame;

endmodule

`default_nettype wire

>>> rtl/packed_yuv422_to_rgb_top.sv
// Packed 4:2:2 camera stream to 24-bit RGB.
// stream_i takes one raw byte per transfer, in Y0 U Y1 V or U Y0 V Y1 order
// as byte_order selects. Every fourth byte completes a macropixel, and
// pixel_o then gives two pixels sharing its chroma: the first with
// second_of_pair low, the second with second_of_pair high and the line and
// frame end flags.
// cfg_i writes byte_order (index 0), frame_width (1) and frame_height (2);
// it is always ready, and writes to other indexes are dropped. Write only
// while the stream is idle.
// The first pixel is valid in the cycle after the fourth byte's transfer,
// the second in the cycle after the receiver takes the first.
// Throughput: one byte per cycle, sustained while the receiver takes every
// pixel, through the single macropixel register feeding pixel_o.
// When the receiver stalls, the pixel holds; the first three bytes of the
// next macropixel are still taken, and the fourth waits until the second
// pixel of the held macropixel has gone.
// Reset clears the byte phase, counters and output valid, and loads the
// default configuration (YUYV order, 640 x 480).
`timescale 1ns / 1ps
`default_nettype none

module packed_yuv422_to_rgb_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pyr_byte_if.sink  stream_i,
  pyr_cfg_if.sink   cfg_i,
  pyr_pix_if.source pixel_o
);
  import pyr_pkg::*;

  cfg_t  cfg_q;
  logic  slot_free;
  logic  mp_load;
  mpix_t mp;

  // Configuration registers: always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_order   <= ORDER_YUYV;
      cfg_q.frame_width  <= DimW'(640);
      cfg_q.frame_height <= DimW'(480);
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_BYTE_ORDER:   cfg_q.byte_order   <= order_e'(cfg_i.data[0]);
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_i.data;
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_i.data;
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  // Gather bytes into macropixels and track position in the frame
  pyr_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stream_i    (stream_i),
    .cfg_i       (cfg_q),
    .slot_free_i (slot_free),
    .mp_load_o   (mp_load),
    .mp_o        (mp)
  );

  // Hold the macropixel and hand out its two converted pixels
  pyr_pair_buf u_pair_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mp_load_i   (mp_load),
    .mp_i        (mp),
    .slot_free_o (slot_free),
    .pixel_o     (pixel_o)
  );

endmodule

`default_nettype wire

>>> tb/packed_yuv422_to_rgb_top_test.sv
`timescale 1ns / 1ps

module packed_yuv422_to_rgb_top_test;
  import pyr_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_BYTES  = 1650;
  // Cycles to let pass once nothing is expected any more: the first pixel of
  // a macropixel is valid in the cycle after its fourth byte is taken.
  localparam int SETTLE_CYCLES = 8;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int LONG_HOLD     = 200;
  // Hard stop: far beyond the slowest clean run.
  localparam int LIMIT_NS      = 10_000_000;

  // Index that no register answers to; the block must drop such writes.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam rgb_t BLACK   = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
  localparam rgb_t WHITE   = '{blue: 8'd255, green: 8'd255, red: 8'd255};
  localparam rgb_t GREY_16 = '{blue: 8'd16,  green: 8'd16,  red: 8'd16};
  localparam rgb_t GREY_235 = '{blue: 8'd235, green: 8'd235, red: 8'd235};

  // One expected pixel as it should leave pixel_o.
  typedef struct packed {
    rgb_t color;
    logic second;
    logic eol;
    logic eof;
  } pix_due_t;

  // Directed script: either a register write or one stream byte. A byte that
  // completes a macropixel may carry the colours typed in by hand.
  typedef enum logic {
    STEP_REG,
    STEP_BYTE
  } step_e;

  typedef struct {
    step_e      kind;
    logic [1:0] reg_idx;
    logic [12:0] reg_val;
    logic [7:0] data;
    bit         typed;
    rgb_t       want_a;
    rgb_t       want_b;
  } step_t;

  logic clk;
  logic rst_n;

  pyr_byte_if stream_if ();
  pyr_cfg_if  cfg_if ();
  pyr_pix_if  pix_if ();

  packed_yuv422_to_rgb_top uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .stream_i(stream_if),
    .cfg_i   (cfg_if),
    .pixel_o (pix_if)
  );

  // ---------------------------------------------------------------------
  // Converter state as the testbench sees it
  // ---------------------------------------------------------------------
  order_e      pix_order;
  logic [12:0] pix_width;
  logic [12:0] pix_height;
  logic [1:0]  byte_slot;
  logic [7:0]  luma0;
  logic [7:0]  luma1;
  logic [7:0]  chroma_b;
  logic [7:0]  chroma_r;
  int          col_at;
  int          line_at;

  pix_due_t pixels_due[$];
  step_t    script[$];

  int  mismatches;
  int  rx_stall;
  int  rx_calm;
  int  tx_calm;
  bit  hold_req;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [7:0] sat8(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return 8'(x);
  endfunction

  // Absorb one stream byte; on the fourth byte of a macropixel hand back
  // the two pixels it yields and advance the column and row counters.
  function automatic int convert_byte(input logic [7:0] b, output pix_due_t pix_a,
                                      output pix_due_t pix_b);
    int u, v, cb, cr, cg, w, h;
    logic eol, eof;
    pix_a = '0;
    pix_b = '0;
    if (pix_order == ORDER_YUYV) begin
      case (byte_slot)
        2'd0: luma0 = b;
        2'd1: chroma_b = b;
        2'd2: luma1 = b;
        default: chroma_r = b;
      endcase
    end else begin
      case (byte_slot)
        2'd0: chroma_b = b;
        2'd1: luma0 = b;
        2'd2: chroma_r = b;
        default: luma1 = b;
      endcase
    end
    if (byte_slot != 2'd3) begin
      byte_slot = byte_slot + 2'd1;
      return 0;
    end
    byte_slot = 2'd0;

    u  = int'(chroma_b) - 128;
    v  = int'(chroma_r) - 128;
    // arithmetic shifts: round towards minus infinity
    cb = (u * 454) >>> 8;
    cr = (v * 359) >>> 8;
    cg = (u * 88 + v * 183) >>> 8;

    // odd widths round down; clamp both sizes into 2..MAX_DIM / 1..MAX_DIM
    w = int'({pix_width[12:1], 1'b0});
    if (w < 2) w = 2;
    if (w > int'(MAX_DIM)) w = int'(MAX_DIM);
    h = int'(pix_height);
    if (h < 1) h = 1;
    if (h > int'(MAX_DIM)) h = int'(MAX_DIM);

    // counters may already sit past the limit after a size change
    eol = (col_at + 2 >= w);
    eof = eol && (line_at + 1 >= h);

    pix_a.color.blue  = sat8(int'(luma0) + cb);
    pix_a.color.green = sat8(int'(luma0) - cg);
    pix_a.color.red   = sat8(int'(luma0) + cr);
    pix_b.color.blue  = sat8(int'(luma1) + cb);
    pix_b.color.green = sat8(int'(luma1) - cg);
    pix_b.color.red   = sat8(int'(luma1) + cr);
    pix_b.second = 1'b1;
    pix_b.eol    = eol;
    pix_b.eof    = eof;

    if (eol) begin
      col_at  = 0;
      line_at = eof ? 0 : line_at + 1;
    end else begin
      col_at = col_at + 2;
    end
    return 2;
  endfunction

  // Gap lengths: mostly none or short, now and then long, and occasional
  // calm runs with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_reg(input logic [1:0] idx, input logic [12:0] val);
    step_t s;
    s = '{kind: STEP_REG, reg_idx: idx, reg_val: val, data: 8'd0, typed: 1'b0,
          want_a: BLACK, want_b: BLACK};
    script.push_back(s);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input bit typed = 1'b0,
                                   input rgb_t want_a = BLACK, input rgb_t want_b = BLACK);
    step_t s;
    s = '{kind: STEP_BYTE, reg_idx: 2'd0, reg_val: 13'd0, data: b, typed: typed,
          want_a: want_a, want_b: want_b};
    script.push_back(s);
  endfunction

  function automatic void add_mpix(input logic [7:0] b0, b1, b2, b3, input bit typed,
                                   input rgb_t want_a, input rgb_t want_b);
    add_byte(b0);
    add_byte(b1);
    add_byte(b2);
    add_byte(b3, typed, want_a, want_b);
  endfunction

  // Offer one byte after an optional gap and hold it until the transfer.
  // Valid is left high so that back-to-back bytes go without a gap in valid.
  task automatic send_byte(input logic [7:0] b, input int gap, input bit typed,
                           input rgb_t want_a, input rgb_t want_b);
    pix_due_t first, second;
    int made;
    @(negedge clk);
    if (gap > 0) begin
      stream_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    stream_if.valid       <= 1'b1;
    stream_if.stream_byte <= b;
    forever begin
      @(posedge clk);
      if (stream_if.ready) break;
    end
    made = convert_byte(b, first, second);
    if (made == 2) begin
      if (typed) begin
        first.color  = want_a;
        second.color = want_b;
      end
      pixels_due.push_back(first);
      pixels_due.push_back(second);
    end
  endtask

  // Drop valid, wait for every outstanding pixel, then let the pipe drain.
  task automatic settle();
    @(negedge clk);
    stream_if.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_if.ready) break;
    end
    if (idx == CFG_BYTE_ORDER) pix_order = order_e'(val[0]);
    else if (idx == CFG_FRAME_WIDTH) pix_width = val;
    else if (idx == CFG_FRAME_HEIGHT) pix_height = val;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------
  // Pixel receiver: ready pattern, counted down in this process
  // ---------------------------------------------------------------------
  initial begin
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off: let the block fill up and stall its input
        hold_req = 1'b0;
        rx_stall = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        pix_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // Check each pixel transfer against the oldest expectation.
  always @(posedge clk) begin : take_pixel
    pix_due_t want;
    if (rst_n && pix_if.valid && pix_if.ready) begin
      if (pixels_due.size() == 0) begin
        log_mismatch($sformatf("pixel with nothing expected: b=%0d g=%0d r=%0d s=%0b l=%0b f=%0b",
                               pix_if.blue, pix_if.green, pix_if.red,
                               pix_if.second_of_pair, pix_if.end_of_line,
                               pix_if.end_of_frame));
      end else begin
        want = pixels_due.pop_front();
        if (pix_if.blue !== want.color.blue || pix_if.green !== want.color.green ||
            pix_if.red !== want.color.red || pix_if.second_of_pair !== want.second ||
            pix_if.end_of_line !== want.eol || pix_if.end_of_frame !== want.eof) begin
          log_mismatch($sformatf(
              "pixel exp b=%0d g=%0d r=%0d s=%0b l=%0b f=%0b, got b=%0d g=%0d r=%0d s=%0b l=%0b f=%0b",
              want.color.blue, want.color.green, want.color.red, want.second, want.eol,
              want.eof, pix_if.blue, pix_if.green, pix_if.red, pix_if.second_of_pair,
              pix_if.end_of_line, pix_if.end_of_frame));
        end
      end
      rx_stall = pick_gap(rx_calm);
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(LIMIT_NS);
    $display("timed out waiting for the block");
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : main_flow
    int          sent;
    int          round;
    int          burst;
    logic [12:0] width;
    logic [12:0] height;
    logic [7:0]  b;

    clk                   = 1'b0;
    rst_n                 = 1'b0;
    stream_if.valid       = 1'b0;
    stream_if.stream_byte = 8'd0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = 2'd0;
    cfg_if.data           = 13'd0;
    mismatches            = 0;
    rx_stall              = 0;
    rx_calm               = 0;
    tx_calm               = 0;
    hold_req              = 1'b0;

    // reset values of the configuration and of the converter state
    pix_order  = ORDER_YUYV;
    pix_width  = 13'd640;
    pix_height = 13'd480;
    byte_slot  = 2'd0;
    luma0      = 8'd0;
    luma1      = 8'd0;
    chroma_b   = 8'd0;
    chroma_r   = 8'd0;
    col_at     = 0;
    line_at    = 0;

    // Directed part. Neutral chroma gives grey, so those rows are typed in.
    add_mpix(8'h00, 8'h80, 8'hFF, 8'h80, 1'b1, BLACK, WHITE);
    // chroma at both ends in one macropixel: clamps on every channel
    add_mpix(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, BLACK, BLACK);
    add_reg(CFG_SPARE, 13'h1FFF);
    add_reg(CFG_BYTE_ORDER, 13'd1);
    // width below 2 and height 0: every macropixel ends line and frame,
    // and the column counter is already past the new last column
    add_reg(CFG_FRAME_WIDTH, 13'd1);
    add_reg(CFG_FRAME_HEIGHT, 13'd0);
    add_mpix(8'h80, 8'h10, 8'h80, 8'hEB, 1'b1, GREY_16, GREY_235);
    // switch byte order halfway through a macropixel
    add_byte(8'h40);
    add_byte(8'h90);
    add_reg(CFG_BYTE_ORDER, 13'd0);
    add_byte(8'h70);
    add_byte(8'hC0);
    // sizes above the maximum
    add_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    add_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    add_mpix(8'h55, 8'hAA, 8'h33, 8'hCC, 1'b0, BLACK, BLACK);
    // shrink the line under the running column count
    add_reg(CFG_FRAME_WIDTH, 13'd2);
    add_mpix(8'h12, 8'hF0, 8'hED, 8'h0F, 1'b0, BLACK, BLACK);
    // shrink the frame under the running row count
    add_reg(CFG_FRAME_HEIGHT, 13'd1);
    add_mpix(8'hA5, 8'h5A, 8'h3C, 8'hC3, 1'b0, BLACK, BLACK);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == STEP_REG) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_byte(script[i].data, pick_gap(tx_calm), script[i].typed,
                  script[i].want_a, script[i].want_b);
      end
    end

    // Random part: rounds of bytes, each under a fresh configuration.
    // Round lengths need not be multiples of four, so some writes land
    // between the bytes of a macropixel.
    sent  = 0;
    round = 0;
    while (sent < RANDOM_BYTES) begin
      settle();
      write_reg(CFG_BYTE_ORDER, 13'($urandom_range(0, 8191)));
      case ($urandom_range(0, 9))
        0: width = 13'd0;
        1: width = 13'd1;
        2: width = 13'd4096;
        3: width = 13'h1FFF;
        4: width = 13'($urandom_range(0, 8191));
        5: width = 13'($urandom_range(1, 15)) | 13'd1;
        default: width = 13'($urandom_range(1, 8) * 2);
      endcase
      case ($urandom_range(0, 9))
        0: height = 13'd0;
        1: height = 13'd1;
        2: height = 13'd4096;
        3: height = 13'h1FFF;
        4: height = 13'($urandom_range(0, 8191));
        default: height = 13'($urandom_range(1, 6));
      endcase
      write_reg(CFG_FRAME_WIDTH, width);
      write_reg(CFG_FRAME_HEIGHT, height);

      if (round == 2) begin
        // hold the receiver off while bytes keep coming without gaps
        hold_req = 1'b1;
        tx_calm  = 80;
      end

      burst = $urandom_range(60, 220);
      for (int k = 0; k < burst; k++) begin
        // pause the sender until every pixel so far has been taken
        if (round == 5 && k == burst / 2) settle();
        case ($urandom_range(0, 9))
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = 8'h80;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b, pick_gap(tx_calm), 1'b0, BLACK, BLACK);
      end
      sent += burst;
      round++;
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
